// File: rtl/key_edge_repeat_detector_defines.svh
// ----------------------------------------------------------------------------
// Key edge repeat detector assertion macros
// Concurrent assertion helpers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_EDGE_REPEAT_DETECTOR_DEFINES_SVH
`define KEY_EDGE_REPEAT_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that an expression holds at every clock edge outside reset.
`define KERD_ASSERT(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("kerd assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define KERD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kerd assertion failed");

`else

`define KERD_ASSERT(label, clk, rst, expr)
`define KERD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/kerd_pkg.sv
// ----------------------------------------------------------------------------
// Key edge repeat detector package
// Shared constants, state and result types, and the per-key update function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kerd_pkg;

   localparam int unsigned KEY_COUNT_DEFAULT = 256;
   localparam int unsigned KEY_W             = 8;
   localparam int unsigned BYTE_W            = 8;

   localparam logic [BYTE_W-1:0] THRESHOLD_RESET = 8'd20;
   localparam logic [BYTE_W-1:0] COUNT_MAX       = 8'hFF;
   localparam int unsigned       PRESSED_BIT     = 7;

   typedef struct packed {
      logic [BYTE_W-1:0] prev_byte;
      logic [BYTE_W-1:0] hold_count;
   } key_state_type;

   typedef struct packed {
      logic             en;
      logic [KEY_W-1:0] key;
   } mem_rd_type;

   typedef struct packed {
      logic             en;
      logic [KEY_W-1:0] key;
      key_state_type    state;
   } mem_wr_type;

   typedef struct packed {
      logic [BYTE_W-1:0] trigger_bits;
      logic [BYTE_W-1:0] release_bits;
      logic [BYTE_W-1:0] repeat_bits;
      logic              is_pressed;
      key_state_type     next_state;
   } key_eval_type;

   // Edge detection and hold counting for one sample of one key.
   function automatic key_eval_type key_eval(
      input logic [BYTE_W-1:0] cur,
      input key_state_type     old,
      input logic [BYTE_W-1:0] threshold
   );
      key_eval_type      res;
      logic [BYTE_W-1:0] diff;
      logic [BYTE_W-1:0] cnt;
      diff             = old.prev_byte ^ cur;
      res.trigger_bits = diff & cur;
      res.release_bits = diff & ~cur;
      res.is_pressed   = cur[PRESSED_BIT];
      res.repeat_bits  = res.trigger_bits;
      if (cur != '0) begin
         cnt = (old.hold_count != COUNT_MAX) ? old.hold_count + 8'd1 : old.hold_count;
         if (cnt >= threshold) begin
            res.repeat_bits = cur;
         end
      end else begin
         cnt             = '0;
         res.repeat_bits = '0;
      end
      res.next_state.prev_byte  = cur;
      res.next_state.hold_count = cnt;
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/kerd_req_if.sv
// ----------------------------------------------------------------------------
// Key sample channel
// Valid/ready channel that carries one key sample word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kerd_req_if;
   logic                            valid;
   logic                            ready;
   logic [kerd_pkg::KEY_W-1:0]      key_index;
   logic [kerd_pkg::BYTE_W-1:0]     key_byte;

   modport source (output valid, output key_index, output key_byte, input ready);
   modport sink   (input valid, input key_index, input key_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/kerd_rsp_if.sv
// ----------------------------------------------------------------------------
// Key result channel
// Valid/ready channel that carries one edge and repeat result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kerd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [kerd_pkg::KEY_W-1:0]      key_number;
   logic [kerd_pkg::BYTE_W-1:0]     trigger_bits;
   logic [kerd_pkg::BYTE_W-1:0]     release_bits;
   logic [kerd_pkg::BYTE_W-1:0]     repeat_bits;
   logic                            is_pressed;

   modport source (
      output valid, output key_number, output trigger_bits, output release_bits,
      output repeat_bits, output is_pressed, input ready
   );
   modport sink (
      input valid, input key_number, input trigger_bits, input release_bits,
      input repeat_bits, input is_pressed, output ready
   );
endinterface

`default_nettype wire

// File: rtl/kerd_state_mem.sv
// ----------------------------------------------------------------------------
// Key state memory
// Per-key previous byte and hold count, one write and one registered read
// port, with a valid bit per key so that unwritten keys read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kerd_state_mem #(
   parameter int unsigned KEY_COUNT = kerd_pkg::KEY_COUNT_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  kerd_pkg::mem_rd_type    rd_req,
   input  kerd_pkg::mem_wr_type    wr_req,
   output kerd_pkg::key_state_type rd_state
);

   localparam int unsigned AddrW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

   kerd_pkg::key_state_type mem_ff [KEY_COUNT];
   logic [KEY_COUNT-1:0]    key_valid_ff;
   kerd_pkg::key_state_type rd_data_ff;
   logic                    rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem_ff[wr_req.key[AddrW-1:0]] <= wr_req.state;
      end
      if (rd_req.en) begin
         rd_data_ff <= mem_ff[rd_req.key[AddrW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_req.en) begin
            key_valid_ff[wr_req.key[AddrW-1:0]] <= 1'b1;
         end
         if (rd_req.en) begin
            rd_valid_ff <= key_valid_ff[rd_req.key[AddrW-1:0]];
         end
      end
   end

   // A key that was never written since reset reads as all zero.
   assign rd_state = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// File: rtl/key_edge_repeat_detector.sv
// A word accepted into the s1 register is evaluated there and moves into the result register when s1 advances.
// Throughput: one word per cycle, held up only by backpressure on the result side.
// The per-key state memory has one read and one write port; the state written
// by the word ahead is forwarded when the next word hits the same key.
// Reset is synchronous: pipeline and per-key valid bits clear at once, the
// threshold returns to 20, and words are accepted right after reset.
// ----------------------------------------------------------------------------
// Key edge repeat detector
// Per-key press/release edge detection with hold counting and auto-repeat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "key_edge_repeat_detector_defines.svh"

module key_edge_repeat_detector #(
   parameter int unsigned KEY_COUNT = kerd_pkg::KEY_COUNT_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   kerd_req_if.sink                    req_ch,
   kerd_rsp_if.source                  rsp_ch,
   input  logic                        csr_write_en,
   input  logic [kerd_pkg::BYTE_W-1:0] csr_write_data
);

   logic [kerd_pkg::BYTE_W-1:0] threshold_ff;
   logic                        s1_valid_ff, s1_valid_in;
   logic [kerd_pkg::KEY_W-1:0]  s1_key_ff;
   logic [kerd_pkg::BYTE_W-1:0] s1_byte_ff;
   logic                        fwd_ff, fwd_in;
   kerd_pkg::key_state_type     fwd_state_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [kerd_pkg::KEY_W-1:0]  rsp_key_ff;
   logic [kerd_pkg::BYTE_W-1:0] rsp_trigger_ff;
   logic [kerd_pkg::BYTE_W-1:0] rsp_release_ff;
   logic [kerd_pkg::BYTE_W-1:0] rsp_repeat_ff;
   logic                        rsp_pressed_ff;

   logic                        req_accept;
   logic                        s1_advance;
   logic                        s1_in_range;
   kerd_pkg::key_state_type     mem_rd_state;
   kerd_pkg::key_state_type     old_state;
   kerd_pkg::key_eval_type      eval;
   kerd_pkg::mem_rd_type        mem_rd;
   kerd_pkg::mem_wr_type        mem_wr;

   assign req_accept  = req_ch.valid & req_ch.ready;
   assign s1_advance  = s1_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_ch.ready = ~s1_valid_ff | s1_advance;

   assign s1_in_range = {1'b0, s1_key_ff} < (kerd_pkg::KEY_W + 1)'(KEY_COUNT);

   // The memory read for this word missed the write of the word ahead when
   // both hit the same key, so that write is taken from the forward register.
   always_comb begin
      if (!s1_in_range) begin
         old_state = '0;
      end else if (fwd_ff) begin
         old_state = fwd_state_ff;
      end else begin
         old_state = mem_rd_state;
      end
      eval = kerd_pkg::key_eval(s1_byte_ff, old_state, threshold_ff);
   end

   always_comb begin
      mem_rd.en    = req_accept;
      mem_rd.key   = req_ch.key_index;
      mem_wr.en    = s1_advance & s1_in_range;
      mem_wr.key   = s1_key_ff;
      mem_wr.state = eval.next_state;
   end

   kerd_state_mem #(
      .KEY_COUNT (KEY_COUNT)
   ) u_state_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_req   (mem_rd),
      .wr_req   (mem_wr),
      .rd_state (mem_rd_state)
   );

   always_comb begin
      s1_valid_in  = req_accept | (s1_valid_ff & ~s1_advance);
      rsp_valid_in = s1_advance | (rsp_valid_ff & ~rsp_ch.ready);
      fwd_in       = s1_advance & s1_in_range & (s1_key_ff == req_ch.key_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= kerd_pkg::THRESHOLD_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            threshold_ff <= csr_write_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_key_ff    <= req_ch.key_index;
         s1_byte_ff   <= req_ch.key_byte;
         fwd_ff       <= fwd_in;
         fwd_state_ff <= eval.next_state;
      end
      if (s1_advance) begin
         rsp_key_ff     <= s1_key_ff;
         rsp_trigger_ff <= eval.trigger_bits;
         rsp_release_ff <= eval.release_bits;
         rsp_repeat_ff  <= eval.repeat_bits;
         rsp_pressed_ff <= eval.is_pressed;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.key_number   = rsp_key_ff;
   assign rsp_ch.trigger_bits = rsp_trigger_ff;
   assign rsp_ch.release_bits = rsp_release_ff;
   assign rsp_ch.repeat_bits  = rsp_repeat_ff;
   assign rsp_ch.is_pressed   = rsp_pressed_ff;

   `KERD_ASSERT_NEXT(a_accept_loads_s1, clock, reset, req_accept,
      s1_valid_ff && (s1_key_ff == $past(req_ch.key_index)))
   `KERD_ASSERT_NEXT(a_advance_loads_rsp, clock, reset, s1_advance,
      rsp_valid_ff && (rsp_key_ff == $past(s1_key_ff)))
   `KERD_ASSERT_NEXT(a_stalled_s1_holds, clock, reset, s1_valid_ff && !s1_advance,
      s1_valid_ff && $stable(s1_key_ff) && $stable(s1_byte_ff))
   `KERD_ASSERT(a_edges_consistent, clock, reset,
      !rsp_valid_ff || (((rsp_trigger_ff & rsp_release_ff) == '0) &&
      ((rsp_trigger_ff & ~rsp_repeat_ff) == '0)))

endmodule

`default_nettype wire

// File: test/key_edge_repeat_detector_tb.sv
// ----------------------------------------------------------------------------
// Key edge repeat detector testbench
// Sends key sample words with random gaps on the input side and random stalls
// on the result side. Each accepted word is run through a per-key predictor
// of the edge, release and repeat logic, and every result word is checked
// field by field against the oldest prediction. The threshold register is
// rewritten between phases, including both ends of its range and zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_edge_repeat_detector_tb;

   localparam int unsigned KEYS           = kerd_pkg::KEY_COUNT_DEFAULT;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          SLOTS          = 6;
   localparam int          PHASE_WORDS    = 220;
   localparam int          SATURATE_HOLD  = 262;

   typedef logic [kerd_pkg::KEY_W-1:0]  key_type;
   typedef logic [kerd_pkg::BYTE_W-1:0] byte_type;

   typedef struct packed {
      key_type  key;
      byte_type state_byte;
   } key_word_type;

   typedef struct packed {
      key_type  key;
      byte_type trigger_bits;
      byte_type release_bits;
      byte_type repeat_bits;
      logic     is_pressed;
   } key_result_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_write_en;
   byte_type csr_write_data;

   kerd_req_if req_ch ();
   kerd_rsp_if rsp_ch ();

   key_edge_repeat_detector dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // Predictor state: last byte and hold count per key, and the threshold.
   byte_type last_byte   [KEYS];
   byte_type held_frames [KEYS];
   byte_type threshold_now;

   key_word_type   pending_words [$];
   key_result_type expected_results [$];

   int mismatch_count = 0;
   int words_offered  = 0;
   int words_taken    = 0;
   int results_seen   = 0;
   int results_last   = 0;
   int send_gap       = 0;
   int rsp_stall      = 0;
   int idle_cycles    = 0;
   bit word_held      = 1'b0;
   bit send_idle_on   = 1'b1;
   bit recv_idle_on   = 1'b1;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic key_result_type predict_key_word(input key_word_type w);
      key_result_type r;
      byte_type       changed;
      byte_type       frames;
      changed        = last_byte[w.key] ^ w.state_byte;
      frames         = held_frames[w.key];
      r.key          = w.key;
      r.trigger_bits = changed & w.state_byte;
      r.release_bits = changed & ~w.state_byte;
      r.is_pressed   = w.state_byte[kerd_pkg::PRESSED_BIT];
      r.repeat_bits  = r.trigger_bits;
      if (w.state_byte == '0) begin
         frames        = '0;
         r.repeat_bits = '0;
      end else begin
         // The hold count sticks at its top value instead of wrapping.
         if (frames != kerd_pkg::COUNT_MAX) begin
            frames = frames + 8'd1;
         end
         if (frames >= threshold_now) begin
            r.repeat_bits = w.state_byte;
         end
      end
      last_byte[w.key]   = w.state_byte;
      held_frames[w.key] = frames;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic queue_word(input key_type key, input byte_type state_byte);
      key_word_type w;
      w.key        = key;
      w.state_byte = state_byte;
      pending_words.push_back(w);
   endtask

   // Lets every queued word through and every result out, plus the latency.
   task automatic wait_drained();
      while (pending_words.size() != 0 || word_held || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_threshold(input byte_type value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      threshold_now  = value;
   endtask

   // Input driver: presents the next pending word after a random gap.
   always @(negedge clock) begin
      key_word_type next_word;
      if (!reset) begin
         if (word_held && words_taken == words_offered) begin
            word_held = 1'b0;
            send_gap  = send_idle_on ? $urandom_range(0, 10) : 0;
         end
         if (!word_held) begin
            if (send_gap == 0 && pending_words.size() > 0) begin
               next_word = pending_words.pop_front();
               word_held = 1'b1;
               words_offered++;
               req_ch.key_index <= next_word.key;
               req_ch.key_byte  <= next_word.state_byte;
            end else if (send_gap > 0) begin
               send_gap--;
            end
         end
         req_ch.valid <= word_held;
      end
   end

   // Result side ready: a fresh stall is drawn after each accepted result.
   always @(negedge clock) begin
      if (!reset) begin
         if (results_seen != results_last) begin
            results_last = results_seen;
            rsp_stall    = recv_idle_on ? $urandom_range(0, 10) : 0;
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Predicts the result of every word the block accepts.
   always @(posedge clock) begin
      key_word_type w;
      if (!reset && req_ch.valid && req_ch.ready) begin
         w.key        = req_ch.key_index;
         w.state_byte = req_ch.key_byte;
         expected_results.push_back(predict_key_word(w));
         words_taken++;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      key_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result word for key %0d", rsp_ch.key_number));
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.key_number !== want.key) begin
               report_mismatch($sformatf("key_number got %02h, expected %02h",
                                         rsp_ch.key_number, want.key));
            end
            if (rsp_ch.trigger_bits !== want.trigger_bits) begin
               report_mismatch($sformatf("key %0d trigger_bits got %02h, expected %02h",
                                         want.key, rsp_ch.trigger_bits, want.trigger_bits));
            end
            if (rsp_ch.release_bits !== want.release_bits) begin
               report_mismatch($sformatf("key %0d release_bits got %02h, expected %02h",
                                         want.key, rsp_ch.release_bits, want.release_bits));
            end
            if (rsp_ch.repeat_bits !== want.repeat_bits) begin
               report_mismatch($sformatf("key %0d repeat_bits got %02h, expected %02h",
                                         want.key, rsp_ch.repeat_bits, want.repeat_bits));
            end
            if (rsp_ch.is_pressed !== want.is_pressed) begin
               report_mismatch($sformatf("key %0d is_pressed got %0b, expected %0b",
                                         want.key, rsp_ch.is_pressed, want.is_pressed));
            end
         end
      end
   end

   // Ends the run when neither channel moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      int       thr;
      int       slot;
      int       hold_cap;
      key_type  slot_key     [SLOTS];
      byte_type slot_byte    [SLOTS];
      int       hold_left    [SLOTS];
      bit       release_due  [SLOTS];
      key_type  saturate_key;

      req_ch.valid     = 1'b0;
      req_ch.key_index = '0;
      req_ch.key_byte  = '0;
      rsp_ch.ready     = 1'b0;
      csr_write_en     = 1'b0;
      csr_write_data   = kerd_pkg::THRESHOLD_RESET;
      threshold_now    = kerd_pkg::THRESHOLD_RESET;
      for (int k = 0; k < KEYS; k++) begin
         last_byte[k]   = '0;
         held_frames[k] = '0;
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words at the reset threshold: press, hold, release, extremes.
      queue_word(8'd0,   8'h80);
      queue_word(8'd0,   8'h80);
      queue_word(8'd0,   8'h00);
      queue_word(8'd255, 8'hFF);
      queue_word(8'd255, 8'h00);
      queue_word(8'd1,   8'h55);
      queue_word(8'd1,   8'hAA);
      queue_word(8'd1,   8'h00);
      queue_word(8'd128, 8'h7F);
      queue_word(8'd128, 8'h01);
      queue_word(8'd0,   8'hFF);
      wait_drained();

      // A zero threshold makes repeat follow every nonzero byte at once.
      write_threshold(8'd0);
      queue_word(8'd2, 8'h01);
      queue_word(8'd2, 8'h01);
      queue_word(8'd2, 8'h00);
      queue_word(8'd2, 8'h80);
      wait_drained();

      write_threshold(8'd1);
      queue_word(8'd3, 8'h80);
      queue_word(8'd3, 8'h80);
      queue_word(8'd3, 8'h00);
      queue_word(8'd255, 8'h00);
      wait_drained();

      // Hold one key past 255 frames at the top threshold so the count saturates.
      write_threshold(8'd255);
      saturate_key = key_type'($urandom_range(0, 255));
      for (int i = 0; i < SATURATE_HOLD; i++) begin
         queue_word(saturate_key, byte_type'($urandom_range(1, 255)));
         if ($urandom_range(0, 3) == 0) begin
            queue_word(key_type'($urandom_range(0, 255)), byte_type'($urandom_range(0, 255)));
         end
      end
      queue_word(saturate_key, 8'h00);
      queue_word(saturate_key, 8'h80);
      wait_drained();

      for (int s = 0; s < SLOTS; s++) begin
         slot_key[s]    = key_type'($urandom_range(0, 255));
         hold_left[s]   = 0;
         release_due[s] = 1'b0;
      end

      for (int p = 1; p < 8; p++) begin
         case (p)
            1: thr = 1;
            2: thr = 0;
            5: thr = $urandom_range(13, 255);
            default: thr = $urandom_range(2, 12);
         endcase
         write_threshold(byte_type'(thr));
         send_idle_on = (p % 3 != 1) && (p != 4);
         recv_idle_on = (p % 3 != 2) && (p != 4);
         hold_cap = (thr + 6 < 60) ? thr + 6 : 60;

         // Interleaved press-hold-release sequences on a few keys, with noise.
         for (int n = 0; n < PHASE_WORDS; n++) begin
            slot = $urandom_range(0, SLOTS - 1);
            if ($urandom_range(0, 9) == 0) begin
               queue_word(key_type'($urandom_range(0, 255)), byte_type'($urandom_range(0, 255)));
            end else if (hold_left[slot] > 0) begin
               if ($urandom_range(0, 7) == 0) begin
                  slot_byte[slot] = slot_byte[slot] ^ byte_type'($urandom_range(1, 255));
                  if (slot_byte[slot] == '0) begin
                     slot_byte[slot] = 8'h80;
                  end
               end
               queue_word(slot_key[slot], slot_byte[slot]);
               hold_left[slot]--;
               if (hold_left[slot] == 0) begin
                  release_due[slot] = 1'b1;
               end
            end else if (release_due[slot]) begin
               queue_word(slot_key[slot], 8'h00);
               release_due[slot] = 1'b0;
               if ($urandom_range(0, 3) == 0) begin
                  slot_key[slot] = key_type'($urandom_range(0, 255));
               end
            end else begin
               slot_byte[slot] = byte_type'($urandom_range(1, 255));
               queue_word(slot_key[slot], slot_byte[slot]);
               hold_left[slot] = $urandom_range(0, hold_cap);
               release_due[slot] = (hold_left[slot] == 0);
            end
         end
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
